@@ src/smpr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed period meter package
// Shared constants, register indexes, event codes and interface structs.
// ----------------------------------------------------------------------------
package smpr_pkg;

    // Default datapath sizing.
    localparam int TIME_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 8;

    // Fixed port widths.
    localparam int TS_W    = 32;
    localparam int AVG_W   = 40;
    localparam int ALPHA_W = 16;
    localparam int IVL_W   = 32;
    localparam int WARM_W  = 8;
    localparam int CNT_W   = 8;
    localparam int CIDX_W  = 2;
    localparam int CDAT_W  = 32;

    // Register indexes on the configuration port.
    localparam logic [CIDX_W-1:0] REG_SMOOTHING       = 2'd0;
    localparam logic [CIDX_W-1:0] REG_REPORT_INTERVAL = 2'd1;
    localparam logic [CIDX_W-1:0] REG_WARMUP_CALLS    = 2'd2;

    // Register reset values.
    localparam logic [ALPHA_W-1:0] SMOOTHING_RST = 16'd6554;
    localparam logic [IVL_W-1:0]   INTERVAL_RST  = 32'd1000000;
    localparam logic [WARM_W-1:0]  WARMUP_RST    = 8'd10;

    // Event codes.
    localparam logic KIND_START = 1'b0;
    localparam logic KIND_END   = 1'b1;

    // Start count at which the period filter is seeded, and its ceiling.
    localparam logic [CNT_W-1:0] SEED_COUNT = 8'd1;
    localparam logic [CNT_W-1:0] COUNT_MAX  = 8'd255;

    // Live configuration.
    typedef struct packed {
        logic [ALPHA_W-1:0] smoothing;
        logic [IVL_W-1:0]   report_interval;
        logic [WARM_W-1:0]  warmup_calls;
    } cfg_t;

    // One result request.
    typedef struct packed {
        logic [AVG_W-1:0] period_avg;
        logic [AVG_W-1:0] runtime_avg;
        logic             period_valid;
        logic             runtime_valid;
        logic             report;
    } result_t;

endpackage

@@ src/smpr_cfg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration registers
// Holds smoothing weight, report interval and warmup count.
// ----------------------------------------------------------------------------
module smpr_cfg
    import smpr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_write,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CDAT_W-1:0] cfg_data,
    output cfg_t              cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the write into the addressed register.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_write)
        begin
            unique case (cfg_index)
                REG_SMOOTHING:       cfg_next.smoothing       = cfg_data[ALPHA_W-1:0];
                REG_REPORT_INTERVAL: cfg_next.report_interval = cfg_data[IVL_W-1:0];
                REG_WARMUP_CALLS:    cfg_next.warmup_calls    = cfg_data[WARM_W-1:0];
                default:             cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.smoothing       <= SMOOTHING_RST;
            cfg_reg.report_interval <= INTERVAL_RST;
            cfg_reg.warmup_calls    <= WARMUP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

@@ src/smpr_ema.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Moving average step
// Moves a filter value toward a sample by a rounded alpha fraction of the gap.
// ----------------------------------------------------------------------------
module smpr_ema
    import smpr_pkg::*;
#(
    parameter int FW = TIME_BITS_DEF + FRAC_BITS_DEF
)
(
    input  logic [FW-1:0]      filt,
    input  logic [FW-1:0]      sample,
    input  logic [ALPHA_W-1:0] alpha,
    output logic [FW-1:0]      filt_new
);

    localparam int PW = FW + ALPHA_W;

    logic          rising;
    logic [FW-1:0] gap;
    logic [PW-1:0] prod;
    logic [FW-1:0] step;

    // Magnitude of the gap between sample and filter.
    assign rising = (sample >= filt);
    assign gap    = rising ? (sample - filt) : (filt - sample);

    // Scale by alpha with halves rounded up; the step never exceeds the gap.
    assign prod = PW'(gap) * PW'(alpha) + PW'(1 << (ALPHA_W - 1));
    assign step = FW'(prod >> ALPHA_W);

    assign filt_new = rising ? (filt + step) : (filt - step);

endmodule

@@ src/smpr_update.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Meter state update
// Holds the filter state and computes the result of one event.
// ----------------------------------------------------------------------------
module smpr_update
    import smpr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  logic            kind,
    input  logic [TS_W-1:0] timestamp,
    input  cfg_t            cfg,
    output result_t         result
);

    localparam int TW = TIME_BITS;
    localparam int FW = TIME_BITS + FRAC_BITS;
    localparam int CW = (TW > IVL_W) ? TW : IVL_W;

    logic [TW-1:0]    last_start_reg,     last_start_next;
    logic [TW-1:0]    last_report_reg,    last_report_next;
    logic [FW-1:0]    period_filter_reg,  period_filter_next;
    logic [FW-1:0]    runtime_filter_reg, runtime_filter_next;
    logic [CNT_W-1:0] start_count_reg,    start_count_next;
    logic             period_seeded_reg,  period_seeded_next;
    logic             runtime_seeded_reg, runtime_seeded_next;

    logic [TW-1:0] t;
    logic [TW-1:0] since_start;
    logic [FW-1:0] sample;
    logic [FW-1:0] ema_filt;
    logic [FW-1:0] ema_out;
    logic [TW-1:0] report_base;
    logic [TW-1:0] since_report;
    logic          report;

    // Event time and the fixed-point time since the last start.
    assign t           = TW'(timestamp);
    assign since_start = t - last_start_reg;
    assign sample      = FW'(since_start) << FRAC_BITS;

    // One shared averaging step: period on starts, runtime on ends.
    assign ema_filt = (kind == KIND_START) ? period_filter_reg : runtime_filter_reg;

    smpr_ema #(
        .FW (FW)
    ) u_ema (
        .filt     (ema_filt),
        .sample   (sample),
        .alpha    (cfg.smoothing),
        .filt_new (ema_out)
    );

    // Before seeding, every start moves the report base to its own time.
    assign report_base  = period_seeded_reg ? last_report_reg : t;
    assign since_report = t - report_base;

    // Next state for this event.
    always_comb
    begin
        last_start_next     = last_start_reg;
        last_report_next    = last_report_reg;
        period_filter_next  = period_filter_reg;
        runtime_filter_next = runtime_filter_reg;
        start_count_next    = start_count_reg;
        period_seeded_next  = period_seeded_reg;
        runtime_seeded_next = runtime_seeded_reg;
        report              = 1'b0;

        if (kind == KIND_START)
        begin
            if (period_seeded_reg)
            begin
                period_filter_next = ema_out;
            end
            else if (start_count_reg == SEED_COUNT)
            begin
                period_filter_next = sample;
                period_seeded_next = 1'b1;
            end
            last_start_next = t;
            if (start_count_reg != COUNT_MAX)
            begin
                start_count_next = start_count_reg + 1'b1;
            end
            report           = (CW'(since_report) > CW'(cfg.report_interval));
            last_report_next = report ? t : report_base;
        end
        else
        begin
            if (period_seeded_reg && (start_count_reg > cfg.warmup_calls))
            begin
                runtime_filter_next = runtime_seeded_reg ? ema_out : sample;
                runtime_seeded_next = 1'b1;
            end
        end
    end

    // State advances only when the event is passed on.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_start_reg     <= '0;
            last_report_reg    <= '0;
            period_filter_reg  <= '0;
            runtime_filter_reg <= '0;
            start_count_reg    <= '0;
            period_seeded_reg  <= 1'b0;
            runtime_seeded_reg <= 1'b0;
        end
        else if (fire)
        begin
            last_start_reg     <= last_start_next;
            last_report_reg    <= last_report_next;
            period_filter_reg  <= period_filter_next;
            runtime_filter_reg <= runtime_filter_next;
            start_count_reg    <= start_count_next;
            period_seeded_reg  <= period_seeded_next;
            runtime_seeded_reg <= runtime_seeded_next;
        end
    end

    // Result reflects the state after this event.
    assign result.period_avg    = AVG_W'(period_filter_next);
    assign result.runtime_avg   = AVG_W'(runtime_filter_next);
    assign result.period_valid  = period_seeded_next;
    assign result.runtime_valid = runtime_seeded_next;
    assign result.report        = report;

endmodule

@@ src/smoothed_period_runtime_meter_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Smoothed period and runtime meter
// An accepted request passes the input register, then the result register.
// Throughput: one request per cycle while out_stall is low, set by the single state update stage.
// Reset: filters, counts, flags and pipeline valids clear; registers reload
// their defaults (smoothing 6554, report interval 1000000, warmup 10).
// ----------------------------------------------------------------------------
module smoothed_period_runtime_meter_core
    import smpr_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              cfg_write,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [CDAT_W-1:0] cfg_data,

    input  logic              in_valid,
    output logic              in_stall,
    input  logic              kind,
    input  logic [TS_W-1:0]   timestamp,

    output logic              out_valid,
    input  logic              out_stall,
    output logic [AVG_W-1:0]  period_avg,
    output logic [AVG_W-1:0]  runtime_avg,
    output logic              period_valid,
    output logic              runtime_valid,
    output logic              report
);

    cfg_t            cfg;
    result_t         result;

    logic            in_valid_reg;
    logic            kind_reg;
    logic [TS_W-1:0] timestamp_reg;
    logic            out_valid_reg;
    result_t         result_reg;

    logic            fire;
    logic            in_take;

    // Configuration registers.
    smpr_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // Handshake: the held request moves on when the result register frees.
    assign fire     = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall = in_valid_reg && !fire;
    assign in_take  = in_valid && !in_stall;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            kind_reg      <= kind;
            timestamp_reg <= timestamp;
        end
    end

    // State update and filter arithmetic.
    smpr_update #(
        .TIME_BITS (TIME_BITS),
        .FRAC_BITS (FRAC_BITS)
    ) u_update (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .kind      (kind_reg),
        .timestamp (timestamp_reg),
        .cfg       (cfg),
        .result    (result)
    );

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            result_reg <= result;
        end
    end

    assign out_valid     = out_valid_reg;
    assign period_avg    = result_reg.period_avg;
    assign runtime_avg   = result_reg.runtime_avg;
    assign period_valid  = result_reg.period_valid;
    assign runtime_valid = result_reg.runtime_valid;
    assign report        = result_reg.report;

endmodule
